[design/tlr_pkg.sv]
// ---------------------------------------------------------------------------
// tlr_pkg: shared definitions of the thick line rasterizer
// Codes, fixed field widths and the flag group passed from the step unit.
// ---------------------------------------------------------------------------
package tlr_pkg;

	// Widths fixed by the interface.
	localparam int CANVAS_W    = 15;
	localparam int THICK_W     = 5;
	localparam int COLOR_W     = 32;
	localparam int CFG_INDEX_W = 2;

	// Offsets run over -15 .. 15 at most, since thickness is a 5-bit field.
	localparam int OFS_W = 6;

	// Request kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// Result status codes.
	localparam logic STATUS_PIXEL = 1'b0;
	localparam logic STATUS_IDLE  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

	// Reset values of the canvas registers.
	localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 15'd640;
	localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 15'd480;

	// Per-pixel decisions taken by the step unit.
	typedef struct packed {
		logic in_canvas;
		logic at_end;
		logic final_copy;
	} tlr_flags_t;

endpackage

[design/tlr_step.sv]
// ---------------------------------------------------------------------------
// tlr_step: one Bresenham step
// Classifies the current pixel and computes the next pixel and error term.
// ---------------------------------------------------------------------------
module tlr_step #(
	parameter int COORD_BITS = 16
) (
	input  logic signed [COORD_BITS:0]         cur_x,
	input  logic signed [COORD_BITS:0]         cur_y,
	input  logic signed [COORD_BITS:0]         copy_end_x,
	input  logic signed [COORD_BITS:0]         copy_end_y,
	input  logic signed [COORD_BITS+2:0]       error_term,
	input  logic [COORD_BITS-1:0]              delta_x,
	input  logic [COORD_BITS-1:0]              delta_y,
	input  logic [1:0]                         step_signs,
	input  logic signed [tlr_pkg::OFS_W-1:0]   offset_x,
	input  logic signed [tlr_pkg::OFS_W-1:0]   offset_y,
	input  logic signed [tlr_pkg::OFS_W-1:0]   offset_last,
	input  logic [tlr_pkg::CANVAS_W-1:0]       canvas_width,
	input  logic [tlr_pkg::CANVAS_W-1:0]       canvas_height,
	output logic signed [COORD_BITS:0]         next_x,
	output logic signed [COORD_BITS:0]         next_y,
	output logic signed [COORD_BITS+2:0]       next_error,
	output tlr_pkg::tlr_flags_t                flags
);

	localparam int CW   = COORD_BITS + 1;
	localparam int EW   = COORD_BITS + 3;
	localparam int CMPW = (CW > tlr_pkg::CANVAS_W) ? CW : tlr_pkg::CANVAS_W;

	logic signed [EW:0]   e2;
	logic signed [EW:0]   dx_ext;
	logic signed [EW:0]   dy_ext;
	logic                 go_x;
	logic                 go_y;
	logic [EW-1:0]        sub_y;
	logic [EW-1:0]        add_x;
	logic [CW-1:0]        inc_x;
	logic [CW-1:0]        inc_y;
	logic [CW-1:0]        x_bits;
	logic [CW-1:0]        y_bits;

	assign e2     = {error_term, 1'b0};
	assign dx_ext = $signed((EW + 1)'(delta_x));
	assign dy_ext = $signed((EW + 1)'(delta_y));
	assign go_x   = e2 > -dy_ext;
	assign go_y   = e2 < dx_ext;

	assign sub_y = go_x ? EW'(delta_y) : '0;
	assign add_x = go_y ? EW'(delta_x) : '0;
	assign next_error = $signed(EW'(error_term) - sub_y + add_x);

	assign inc_x = go_x ? (step_signs[0] ? CW'(1) : {CW{1'b1}}) : '0;
	assign inc_y = go_y ? (step_signs[1] ? CW'(1) : {CW{1'b1}}) : '0;
	assign next_x = $signed(CW'(cur_x) + inc_x);
	assign next_y = $signed(CW'(cur_y) + inc_y);

	// Non-negative coordinates compare as unsigned against the canvas size.
	assign x_bits = cur_x;
	assign y_bits = cur_y;
	assign flags.in_canvas = !cur_x[CW-1] && !cur_y[CW-1]
		&& (CMPW'(x_bits) < CMPW'(canvas_width))
		&& (CMPW'(y_bits) < CMPW'(canvas_height));
	assign flags.at_end     = (cur_x == copy_end_x) && (cur_y == copy_end_y);
	assign flags.final_copy = (offset_x == offset_last) && (offset_y == offset_last);

endmodule

[design/thick_line_rasterizer_unit.sv]
// ---------------------------------------------------------------------------
// thick_line_rasterizer_unit: stepped thick line rasterizer
// Draws a line of thickness t as t by t offset copies, one pixel per request.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  --------  ---------  -------------------  ---------------------------------
//  request   in         req_valid/req_stall  kind, endpoints, colour, thickness
//  result    out        res_valid/res_stall  status, pixel x/y, colour, flags
//  config    in         cfg_we               cfg_index, cfg_data (canvas size)
//
// The line state is held in registers; one Bresenham step (a doubled-error
// compare, an add per axis) updates it, while the current pixel goes to the
// result register, so a request can be accepted every cycle unless stalled.
// A start request yields no result; each step request yields exactly one.
// The asynchronous reset clears the line state to idle and the canvas to
// 640 by 480. A stalled result holds in its register; requests are stalled
// only while that register is full and the result side stalls.
// ---------------------------------------------------------------------------
module thick_line_rasterizer_unit #(
	parameter int COORD_BITS    = 16,
	parameter int MAX_THICKNESS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                kind,
	input  logic signed [COORD_BITS-1:0]        x_start,
	input  logic signed [COORD_BITS-1:0]        y_start,
	input  logic signed [COORD_BITS-1:0]        x_end,
	input  logic signed [COORD_BITS-1:0]        y_end,
	input  logic [tlr_pkg::COLOR_W-1:0]         line_color,
	input  logic [tlr_pkg::THICK_W-1:0]         line_thickness,
	// Result channel
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                status,
	output logic signed [COORD_BITS:0]          pixel_x,
	output logic signed [COORD_BITS:0]          pixel_y,
	output logic [tlr_pkg::COLOR_W-1:0]         pixel_color,
	output logic                                inside_res,
	output logic                                last,
	// Configuration port
	input  logic                                cfg_we,
	input  logic [tlr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tlr_pkg::CANVAS_W-1:0]        cfg_data
);

	localparam int CW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;
	localparam int OW = tlr_pkg::OFS_W;
	localparam int TW = tlr_pkg::THICK_W;

	// Configuration registers.
	logic [tlr_pkg::CANVAS_W-1:0] canvas_width_q;
	logic [tlr_pkg::CANVAS_W-1:0] canvas_height_q;

	// Line state.
	logic                         active_q;
	logic signed [CW-1:0]         cur_x_q;
	logic signed [CW-1:0]         cur_y_q;
	logic signed [CW-1:0]         copy_end_x_q;
	logic signed [CW-1:0]         copy_end_y_q;
	logic signed [COORD_BITS-1:0] base_x0_q;
	logic signed [COORD_BITS-1:0] base_y0_q;
	logic signed [COORD_BITS-1:0] base_x1_q;
	logic signed [COORD_BITS-1:0] base_y1_q;
	logic [COORD_BITS-1:0]        delta_x_q;
	logic [COORD_BITS-1:0]        delta_y_q;
	logic [1:0]                   step_signs_q;
	logic signed [EW-1:0]         error_term_q;
	logic signed [OW-1:0]         offset_x_q;
	logic signed [OW-1:0]         offset_y_q;
	logic signed [OW-1:0]         offset_low_q;
	logic signed [OW-1:0]         offset_last_q;
	logic [tlr_pkg::COLOR_W-1:0]  held_color_q;

	// Result register.
	logic                         res_valid_q;
	logic                         status_q;
	logic signed [CW-1:0]         pixel_x_q;
	logic signed [CW-1:0]         pixel_y_q;
	logic [tlr_pkg::COLOR_W-1:0]  pixel_color_q;
	logic                         inside_q;
	logic                         last_q;

	logic req_fire;
	logic do_start;
	logic do_step;

	// Start request decode.
	logic [TW-1:0]            thick_sat;
	logic [TW-2:0]            thick_half;
	logic signed [OW-1:0]     start_low;
	logic signed [OW-1:0]     start_last;
	logic signed [COORD_BITS:0] diff_x;
	logic signed [COORD_BITS:0] diff_y;
	logic signed [COORD_BITS:0] diff_x_neg;
	logic signed [COORD_BITS:0] diff_y_neg;
	logic                     x_up;
	logic                     y_up;
	logic [COORD_BITS-1:0]    start_dx;
	logic [COORD_BITS-1:0]    start_dy;

	// Step unit and copy restart.
	logic signed [CW-1:0]     next_x;
	logic signed [CW-1:0]     next_y;
	logic signed [EW-1:0]     next_error;
	tlr_pkg::tlr_flags_t      flags;
	logic signed [OW-1:0]     copy_ox;
	logic signed [OW-1:0]     copy_oy;

	assign req_stall = res_valid_q && res_stall;
	assign req_fire  = req_valid && !req_stall;
	assign do_start  = req_fire && (kind == tlr_pkg::KIND_START);
	assign do_step   = req_fire && (kind == tlr_pkg::KIND_STEP);

	// Sign-extend a coordinate and add an offset.
	function automatic logic signed [CW-1:0] add_ofs(
		input logic signed [COORD_BITS-1:0] base,
		input logic signed [OW-1:0]         ofs
	);
		add_ofs = $signed({base[COORD_BITS-1], base})
			+ $signed({{(CW - OW){ofs[OW-1]}}, ofs});
	endfunction

	// Thickness is clamped to the largest supported size. The offsets then
	// run from -floor(t/2) up to t - floor(t/2) - 1; we keep the last one.
	assign thick_sat = ({3'b000, line_thickness} > 8'(MAX_THICKNESS))
		? TW'(MAX_THICKNESS) : line_thickness;
	assign thick_half = thick_sat[TW-1:1];
	assign start_low  = -$signed({2'b00, thick_half});
	assign start_last = $signed({1'b0, thick_sat}) - $signed({2'b00, thick_half})
		- OW'(1);

	// Absolute differences and step directions.
	assign diff_x     = $signed({x_end[COORD_BITS-1], x_end})
		- $signed({x_start[COORD_BITS-1], x_start});
	assign diff_y     = $signed({y_end[COORD_BITS-1], y_end})
		- $signed({y_start[COORD_BITS-1], y_start});
	assign diff_x_neg = -diff_x;
	assign diff_y_neg = -diff_y;
	assign x_up       = x_start < x_end;
	assign y_up       = y_start < y_end;
	assign start_dx   = x_up ? diff_x[COORD_BITS-1:0] : diff_x_neg[COORD_BITS-1:0];
	assign start_dy   = y_up ? diff_y[COORD_BITS-1:0] : diff_y_neg[COORD_BITS-1:0];

	tlr_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.cur_x         (cur_x_q),
		.cur_y         (cur_y_q),
		.copy_end_x    (copy_end_x_q),
		.copy_end_y    (copy_end_y_q),
		.error_term    (error_term_q),
		.delta_x       (delta_x_q),
		.delta_y       (delta_y_q),
		.step_signs    (step_signs_q),
		.offset_x      (offset_x_q),
		.offset_y      (offset_y_q),
		.offset_last   (offset_last_q),
		.canvas_width  (canvas_width_q),
		.canvas_height (canvas_height_q),
		.next_x        (next_x),
		.next_y        (next_y),
		.next_error    (next_error),
		.flags         (flags)
	);

	// Offset of the next copy: the vertical offset is the inner loop.
	always_comb begin
		if (offset_y_q != offset_last_q) begin
			copy_ox = offset_x_q;
			copy_oy = offset_y_q + OW'(1);
		end else begin
			copy_ox = offset_x_q + OW'(1);
			copy_oy = offset_low_q;
		end
	end

	// Configuration writes; indexes past the two registers are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= tlr_pkg::CANVAS_WIDTH_RST;
			canvas_height_q <= tlr_pkg::CANVAS_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == tlr_pkg::REG_CANVAS_WIDTH) begin
				canvas_width_q <= cfg_data;
			end
			if (cfg_index == tlr_pkg::REG_CANVAS_HEIGHT) begin
				canvas_height_q <= cfg_data;
			end
		end
	end

	// Control state: line activity and result occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_start) begin
				// A zero thickness draws nothing and leaves the block idle.
				active_q <= (thick_sat != '0);
			end else if (do_step && active_q && flags.at_end && flags.final_copy) begin
				active_q <= 1'b0;
			end
			if (do_step) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Line datapath. A start abandons any line in progress.
	always_ff @(posedge clk) begin
		if (do_start) begin
			base_x0_q     <= x_start;
			base_y0_q     <= y_start;
			base_x1_q     <= x_end;
			base_y1_q     <= y_end;
			held_color_q  <= line_color;
			delta_x_q     <= start_dx;
			delta_y_q     <= start_dy;
			step_signs_q  <= {y_up, x_up};
			offset_low_q  <= start_low;
			offset_last_q <= start_last;
			offset_x_q    <= start_low;
			offset_y_q    <= start_low;
			cur_x_q       <= add_ofs(x_start, start_low);
			cur_y_q       <= add_ofs(y_start, start_low);
			copy_end_x_q  <= add_ofs(x_end, start_low);
			copy_end_y_q  <= add_ofs(y_end, start_low);
			error_term_q  <= $signed(EW'(start_dx) - EW'(start_dy));
		end else if (do_step && active_q) begin
			if (flags.at_end) begin
				if (!flags.final_copy) begin
					// Restart the line for the next offset copy.
					offset_x_q   <= copy_ox;
					offset_y_q   <= copy_oy;
					cur_x_q      <= add_ofs(base_x0_q, copy_ox);
					cur_y_q      <= add_ofs(base_y0_q, copy_oy);
					copy_end_x_q <= add_ofs(base_x1_q, copy_ox);
					copy_end_y_q <= add_ofs(base_y1_q, copy_oy);
					error_term_q <= $signed(EW'(delta_x_q) - EW'(delta_y_q));
				end
			end else begin
				cur_x_q      <= next_x;
				cur_y_q      <= next_y;
				error_term_q <= next_error;
			end
		end
	end

	// Result register: loaded by every step request.
	always_ff @(posedge clk) begin
		if (do_step) begin
			if (active_q) begin
				status_q      <= tlr_pkg::STATUS_PIXEL;
				pixel_x_q     <= cur_x_q;
				pixel_y_q     <= cur_y_q;
				pixel_color_q <= held_color_q;
				inside_q      <= flags.in_canvas;
				last_q        <= flags.at_end && flags.final_copy;
			end else begin
				status_q      <= tlr_pkg::STATUS_IDLE;
				pixel_x_q     <= '0;
				pixel_y_q     <= '0;
				pixel_color_q <= '0;
				inside_q      <= 1'b0;
				last_q        <= 1'b0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign inside_res  = inside_q;
	assign last        = last_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for thick_line_rasterizer_unit
// Random start and step requests, mostly complete lines near the canvas
// edges, are checked pixel by pixel against an in-bench line stepper
// across several canvas sizes, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb;

	localparam int COORD_BITS     = 16;
	localparam int MAX_THICKNESS  = 16;
	localparam int HALF_PERIOD_NS = 5;
	localparam int RESET_CYCLES   = 5;
	// The result leaves a single register, so SETTLE_CYCLES covers any work
	// still under way once the last expected pixel has been seen.
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_NS    = 2_000_000;
	localparam int SHOW_LIMIT     = 10;

	// Indexes with no register behind them; writes to these are dropped.
	localparam logic [tlr_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [tlr_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic                        kind;
		logic [COORD_BITS-1:0]       xs;
		logic [COORD_BITS-1:0]       ys;
		logic [COORD_BITS-1:0]       xe;
		logic [COORD_BITS-1:0]       ye;
		logic [tlr_pkg::COLOR_W-1:0] color;
		logic [tlr_pkg::THICK_W-1:0] thick;
	} line_req_t;

	typedef struct packed {
		logic                        status;
		logic [COORD_BITS:0]         px;
		logic [COORD_BITS:0]         py;
		logic [tlr_pkg::COLOR_W-1:0] color;
		logic                        in_canvas;
		logic                        last;
	} pixel_t;

	// Clock, reset and every block input start from known values.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                         req_valid      = 1'b0;
	logic                         req_stall;
	logic                         kind           = tlr_pkg::KIND_STEP;
	logic signed [COORD_BITS-1:0] x_start        = '0;
	logic signed [COORD_BITS-1:0] y_start        = '0;
	logic signed [COORD_BITS-1:0] x_end          = '0;
	logic signed [COORD_BITS-1:0] y_end          = '0;
	logic [tlr_pkg::COLOR_W-1:0]  line_color     = '0;
	logic [tlr_pkg::THICK_W-1:0]  line_thickness = '0;

	logic                         res_valid;
	logic                         res_stall      = 1'b0;
	logic                         status;
	logic signed [COORD_BITS:0]   pixel_x;
	logic signed [COORD_BITS:0]   pixel_y;
	logic [tlr_pkg::COLOR_W-1:0]  pixel_color;
	logic                         inside_res;
	logic                         last;

	logic                              cfg_we    = 1'b0;
	logic [tlr_pkg::CFG_INDEX_W-1:0]   cfg_index = tlr_pkg::REG_CANVAS_WIDTH;
	logic [tlr_pkg::CANVAS_W-1:0]      cfg_data  = '0;

	thick_line_rasterizer_unit #(
		.COORD_BITS    (COORD_BITS),
		.MAX_THICKNESS (MAX_THICKNESS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.kind           (kind),
		.x_start        (x_start),
		.y_start        (y_start),
		.x_end          (x_end),
		.y_end          (y_end),
		.line_color     (line_color),
		.line_thickness (line_thickness),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.status         (status),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_color    (pixel_color),
		.inside_res     (inside_res),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(HALF_PERIOD_NS) clk = ~clk;

	// Requests waiting to be driven, and pixels the block still owes us.
	line_req_t pending_requests[$];
	pixel_t    expected_pixels[$];
	int        requests_outstanding = 0;
	int        phase_items          = 0;
	int        error_count          = 0;

	// Handshake bookkeeping shared between the clock edges.
	bit req_taken = 1'b0;
	bit res_taken = 1'b0;
	bit req_calm  = 1'b0;
	bit res_calm  = 1'b0;
	int req_gap   = 0;
	int res_wait  = 0;

	// Own copy of the canvas registers and of the line stepper's state.
	logic [tlr_pkg::CANVAS_W-1:0] canvas_w = tlr_pkg::CANVAS_WIDTH_RST;
	logic [tlr_pkg::CANVAS_W-1:0] canvas_h = tlr_pkg::CANVAS_HEIGHT_RST;
	bit                  line_active = 1'b0;
	bit                  x_rising    = 1'b0;
	bit                  y_rising    = 1'b0;
	int                  cur_x = 0, cur_y = 0, stop_x = 0, stop_y = 0;
	int                  base_x0 = 0, base_y0 = 0, base_x1 = 0, base_y1 = 0;
	int                  delta_x = 0, delta_y = 0, err = 0;
	int                  ofs_x = 0, ofs_y = 0, ofs_lo = 0, ofs_hi = 0;
	logic [tlr_pkg::COLOR_W-1:0] held_colour = '0;

	// ------------------------------------------------------------------
	// Line stepper
	// ------------------------------------------------------------------

	// Sets the walk up for the offset copy selected by ofs_x and ofs_y.
	task automatic load_copy();
		cur_x  = base_x0 + ofs_x;
		cur_y  = base_y0 + ofs_y;
		stop_x = base_x1 + ofs_x;
		stop_y = base_y1 + ofs_y;
		err    = delta_x - delta_y;
	endtask

	// Applies one accepted request; a step request queues the pixel it owes.
	task automatic rasterize_request(input line_req_t r);
		pixel_t p;
		int     t;
		int     e2;
		bit     at_end;
		bit     final_copy;
		if (r.kind == tlr_pkg::KIND_START) begin
			// Thickness beyond the supported maximum is clamped to it.
			t = (r.thick > MAX_THICKNESS) ? MAX_THICKNESS : int'(r.thick);
			base_x0     = $signed(r.xs);
			base_y0     = $signed(r.ys);
			base_x1     = $signed(r.xe);
			base_y1     = $signed(r.ye);
			held_colour = r.color;
			x_rising    = base_x0 < base_x1;
			y_rising    = base_y0 < base_y1;
			delta_x     = x_rising ? base_x1 - base_x0 : base_x0 - base_x1;
			delta_y     = y_rising ? base_y1 - base_y0 : base_y0 - base_y1;
			// Odd thickness splits evenly about the line; even thickness
			// puts the extra copy on the negative side.
			if (t % 2 == 0) begin
				ofs_lo = -(t / 2);
				ofs_hi = t / 2;
			end else begin
				ofs_lo = -((t - 1) / 2);
				ofs_hi = (t - 1) / 2 + 1;
			end
			ofs_x       = ofs_lo;
			ofs_y       = ofs_lo;
			line_active = (t != 0);
			load_copy();
		end else begin
			p = '0;
			if (!line_active) begin
				p.status = tlr_pkg::STATUS_IDLE;
			end else begin
				at_end      = (cur_x == stop_x) && (cur_y == stop_y);
				final_copy  = (ofs_x == ofs_hi - 1) && (ofs_y == ofs_hi - 1);
				p.status    = tlr_pkg::STATUS_PIXEL;
				p.px        = cur_x[COORD_BITS:0];
				p.py        = cur_y[COORD_BITS:0];
				p.color     = held_colour;
				p.in_canvas = cur_x >= 0 && cur_y >= 0 &&
				              cur_x < int'(canvas_w) && cur_y < int'(canvas_h);
				p.last      = at_end && final_copy;
				if (at_end) begin
					if (final_copy) begin
						line_active = 1'b0;
					end else begin
						// Vertical offset is the inner loop.
						if (ofs_y < ofs_hi - 1) begin
							ofs_y++;
						end else begin
							ofs_y = ofs_lo;
							ofs_x++;
						end
						load_copy();
					end
				end else begin
					e2 = 2 * err;
					if (e2 > -delta_y) begin
						err   -= delta_y;
						cur_x += x_rising ? 1 : -1;
					end
					if (e2 < delta_x) begin
						err   += delta_x;
						cur_y += y_rising ? 1 : -1;
					end
				end
			end
			expected_pixels.push_back(p);
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 8));
	endfunction

	function automatic logic [COORD_BITS-1:0] to_coord(input int v);
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic int random_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// A line anchor: mostly hugging the origin or the far canvas edge, where
	// clipping changes, with the occasional point at the ends of the range.
	function automatic int pick_anchor(input int span);
		case ($urandom_range(0, 5))
			0, 1: begin
				return int'($urandom_range(0, 24)) - 12;
			end
			2: begin
				return span + int'($urandom_range(0, 24)) - 12;
			end
			3: begin
				return int'($urandom_range(0, span));
			end
			4: begin
				if ($urandom_range(0, 1))
					return -32768 + int'($urandom_range(0, 12));
				return 32767 - int'($urandom_range(0, 12));
			end
			default: begin
				return random_coord();
			end
		endcase
	endfunction

	task automatic queue_start(input int xs, input int ys, input int xe, input int ye,
			input logic [tlr_pkg::COLOR_W-1:0] colour,
			input logic [tlr_pkg::THICK_W-1:0] thick);
		line_req_t r;
		r.kind  = tlr_pkg::KIND_START;
		r.xs    = to_coord(xs);
		r.ys    = to_coord(ys);
		r.xe    = to_coord(xe);
		r.ye    = to_coord(ye);
		r.color = colour;
		r.thick = thick;
		pending_requests.push_back(r);
		requests_outstanding++;
		phase_items++;
	endtask

	// Step requests carry random payload; the block must ignore it.
	task automatic queue_steps(input int n);
		line_req_t r;
		for (int i = 0; i < n; i++) begin
			r.kind  = tlr_pkg::KIND_STEP;
			r.xs    = COORD_BITS'($urandom);
			r.ys    = COORD_BITS'($urandom);
			r.xe    = COORD_BITS'($urandom);
			r.ye    = COORD_BITS'($urandom);
			r.color = $urandom;
			r.thick = tlr_pkg::THICK_W'($urandom);
			pending_requests.push_back(r);
			requests_outstanding++;
			phase_items++;
		end
	endtask

	// One random sequence. Most are a complete line with random content,
	// sometimes run on into the idle state; the rest are lines cut short
	// and abandoned by the next start, full-range starts and idle noise.
	task automatic queue_line_sequence();
		int pick;
		int t;
		int reach;
		int x0, y0, x1, y1;
		int span;
		int pixels;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			queue_start(random_coord(), random_coord(), random_coord(), random_coord(),
			            $urandom, tlr_pkg::THICK_W'($urandom_range(0, 31)));
			queue_steps($urandom_range(0, 5));
		end else if (pick < 12) begin
			if ($urandom_range(0, 1))
				queue_start(random_coord(), random_coord(), random_coord(), random_coord(),
				            $urandom, '0);
			queue_steps($urandom_range(1, 3));
		end else begin
			t = $urandom_range(0, 99);
			if (t < 40)
				t = 1;
			else if (t < 65)
				t = 2;
			else if (t < 83)
				t = 3;
			else if (t < 93)
				t = $urandom_range(4, 5);
			else
				t = $urandom_range(6, 31);
			reach = (t <= 2) ? 12 : (t <= 5) ? 4 : 0;
			x0 = $signed(to_coord(pick_anchor(int'(canvas_w))));
			y0 = $signed(to_coord(pick_anchor(int'(canvas_h))));
			x1 = $signed(to_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach));
			y1 = $signed(to_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach));
			x0 = $signed(to_coord(x0));
			y0 = $signed(to_coord(y0));
			x1 = $signed(to_coord(x1));
			y1 = $signed(to_coord(y1));
			span = (x1 > x0 ? x1 - x0 : x0 - x1);
			if ((y1 > y0 ? y1 - y0 : y0 - y1) > span)
				span = (y1 > y0 ? y1 - y0 : y0 - y1);
			n = (t > MAX_THICKNESS) ? MAX_THICKNESS : t;
			pixels = (span + 1) * n * n;
			queue_start(x0, y0, x1, y1, $urandom, tlr_pkg::THICK_W'(t));
			if (t >= 6 && $urandom_range(0, 3) != 0)
				queue_steps($urandom_range(0, 40));
			else if (pick < 85)
				queue_steps(pixels + (($urandom_range(0, 3) == 0) ? 2 : 0));
			else
				queue_steps($urandom_range(0, pixels - 1));
		end
	endtask

	task automatic queue_random_phase(input int target);
		phase_items = 0;
		while (phase_items < target)
			queue_line_sequence();
	endtask

	// Holds the sender back until every request has gone in and every
	// pixel has come out, then lets the block settle.
	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (requests_outstanding != 0 || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_canvas_reg(input logic [tlr_pkg::CFG_INDEX_W-1:0] index,
			input int value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = index;
		cfg_data  = value[tlr_pkg::CANVAS_W-1:0];
		if (index == tlr_pkg::REG_CANVAS_WIDTH)
			canvas_w = value[tlr_pkg::CANVAS_W-1:0];
		else if (index == tlr_pkg::REG_CANVAS_HEIGHT)
			canvas_h = value[tlr_pkg::CANVAS_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Request driver: presents the next pending request after its drawn
	// gap, and holds it steady until the block takes it.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		line_req_t r;
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap--;
			end else if (pending_requests.size() != 0) begin
				r = pending_requests.pop_front();
				kind           <= r.kind;
				x_start        <= r.xs;
				y_start        <= r.ys;
				x_end          <= r.xe;
				y_end          <= r.ye;
				line_color     <= r.color;
				line_thickness <= r.thick;
				req_valid      <= 1'b1;
				// Now and then switch between idling and back-to-back bursts.
				if ($urandom_range(0, 39) == 0)
					req_calm = !req_calm;
				req_gap = draw_wait(req_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side: after each pixel taken, stall for a drawn number of cycles.
	always @(negedge clk) begin
		if (res_taken) begin
			res_taken = 1'b0;
			if ($urandom_range(0, 39) == 0)
				res_calm = !res_calm;
			res_wait = draw_wait(res_calm);
		end
		if (res_wait > 0) begin
			res_stall <= 1'b1;
			res_wait--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts from each accepted request, then checks each
	// accepted result against the oldest pixel still owed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		line_req_t seen_req;
		pixel_t    got;
		pixel_t    want;
		if (arst_n) begin
			req_taken = req_valid && !req_stall;
			if (req_taken) begin
				seen_req.kind  = kind;
				seen_req.xs    = x_start;
				seen_req.ys    = y_start;
				seen_req.xe    = x_end;
				seen_req.ye    = y_end;
				seen_req.color = line_color;
				seen_req.thick = line_thickness;
				rasterize_request(seen_req);
				requests_outstanding--;
			end
			if (res_valid && !res_stall) begin
				res_taken     = 1'b1;
				got.status    = status;
				got.px        = pixel_x;
				got.py        = pixel_y;
				got.color     = pixel_color;
				got.in_canvas = inside_res;
				got.last      = last;
				if (expected_pixels.size() == 0) begin
					error_count++;
					if (error_count <= SHOW_LIMIT)
						$display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
						         got.status, $signed(got.px), $signed(got.py));
				end else begin
					want = expected_pixels.pop_front();
					if (got.status !== want.status || got.px !== want.px ||
					    got.py !== want.py || got.color !== want.color ||
					    got.in_canvas !== want.in_canvas || got.last !== want.last) begin
						error_count++;
						if (error_count <= SHOW_LIMIT) begin
							$display("%0t: pixel mismatch", $time);
							$display("  expected status=%0d x=%0d y=%0d colour=%08h in=%0d last=%0d",
							         want.status, $signed(want.px), $signed(want.py),
							         want.color, want.in_canvas, want.last);
							$display("  actual   status=%0d x=%0d y=%0d colour=%08h in=%0d last=%0d",
							         got.status, $signed(got.px), $signed(got.py),
							         got.color, got.in_canvas, got.last);
						end
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, on the reset canvas of 640 by 480.
		queue_steps(1);                                        // step while idle
		queue_start(5, 5, 9, 7, 32'h0000_0000, 5'd0);          // zero thickness stays idle
		queue_steps(1);
		queue_start(-32768, -32768, -32768, -32768, 32'hFFFF_FFFF, 5'd31);
		queue_steps(3);                                        // clamped, abandoned
		queue_start(32767, 32767, -32768, -32768, 32'hA5A5_5A5A, 5'd1);
		queue_steps(1);                                        // widest span, abandoned
		queue_start(639, 479, 639, 479, 32'h5A5A_A5A5, 5'd2);  // canvas corner
		queue_steps(5);                                        // runs on into idle
		queue_start(2, 5, -1, 0, $urandom, 5'd1);              // both axes falling
		queue_steps(6);

		queue_random_phase(150);
		wait_for_drain();

		// Empty canvas: every pixel is clipped.
		write_canvas_reg(tlr_pkg::REG_CANVAS_WIDTH, 0);
		write_canvas_reg(tlr_pkg::REG_CANVAS_HEIGHT, 0);
		queue_random_phase(180);
		wait_for_drain();

		// Largest canvas.
		write_canvas_reg(tlr_pkg::REG_CANVAS_WIDTH, 32767);
		write_canvas_reg(tlr_pkg::REG_CANVAS_HEIGHT, 32767);
		queue_random_phase(180);
		wait_for_drain();

		// Tiny canvas, with writes to the unused indexes in between.
		write_canvas_reg(tlr_pkg::REG_CANVAS_WIDTH, 7);
		write_canvas_reg(REG_SPARE_2, $urandom);
		write_canvas_reg(tlr_pkg::REG_CANVAS_HEIGHT, 5);
		write_canvas_reg(REG_SPARE_3, $urandom);
		queue_random_phase(180);
		wait_for_drain();

		write_canvas_reg(tlr_pkg::REG_CANVAS_WIDTH, $urandom_range(0, 1023));
		write_canvas_reg(tlr_pkg::REG_CANVAS_HEIGHT, $urandom_range(0, 1023));
		queue_random_phase(180);
		wait_for_drain();

		write_canvas_reg(tlr_pkg::REG_CANVAS_WIDTH, 640);
		write_canvas_reg(tlr_pkg::REG_CANVAS_HEIGHT, 480);
		queue_random_phase(180);
		wait_for_drain();

		if (expected_pixels.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Watchdog for a block that stops answering.
	initial begin
		#(WATCHDOG_NS);
		$display("tb: FAIL");
		$finish;
	end

endmodule

[sim.f]
design/tlr_pkg.sv
design/tlr_step.sv
design/thick_line_rasterizer_unit.sv
sim/tb.sv
